FILE: hdl/car_pkg.sv
// ----------------------------------------------------------------------------
// car_pkg
// shared types, constants and helper functions for the chunked argmax reduce
// ----------------------------------------------------------------------------
package car_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned CountW = 17;

	typedef enum logic [1:0] {
		VT_FLOAT = 2'd0,
		VT_HALF = 2'd1,
		VT_SIGNED = 2'd2,
		VT_UNSIGNED = 2'd3
	} vtype_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TOTAL = 2'd0,
		REG_CHUNK = 2'd1,
		REG_BASE = 2'd2,
		REG_TYPE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] value;
		logic [31:0] index;
		logic set_done;
	} result_t;

	// exact widening of half to float32
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic s;
		logic [4:0] e;
		logic [9:0] m;
		logic [9:0] mn;
		logic [7:0] ex;
		logic found;
		s = h[15];
		e = h[14:10];
		m = h[9:0];
		mn = '0;
		ex = '0;
		found = 1'b0;
		if (e == 5'd0) begin
			if (m == 10'd0) begin
				half_to_single = {s, 31'd0};
			end else begin
				for (int i = 9; i >= 0; i--) begin
					if (!found && m[i]) begin
						found = 1'b1;
						ex = 8'(103 + i);
						mn = 10'(m << (10 - i));
					end
				end
				half_to_single = {s, ex, mn, 13'd0};
			end
		end else if (e == 5'd31) begin
			half_to_single = {s, 8'hff, m, 13'd0};
		end else begin
			half_to_single = {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
		end
	endfunction

	function automatic logic is_nan32(input logic [31:0] b);
		is_nan32 = (b[30:0] > 31'h7f800000);
	endfunction

	function automatic logic [31:0] order_key(input logic [31:0] b);
		order_key = b[31] ? ~b : (b | 32'h80000000);
	endfunction

	function automatic logic greater(input logic [31:0] a, input logic [31:0] b,
			input vtype_t t);
		case (t)
			VT_FLOAT, VT_HALF: begin
				if (is_nan32(a) || is_nan32(b)) greater = 1'b0;
				else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) greater = 1'b0;
				else greater = order_key(a) > order_key(b);
			end
			VT_SIGNED: greater = (a ^ 32'h80000000) > (b ^ 32'h80000000);
			default: greater = a > b;
		endcase
	endfunction

endpackage

FILE: hdl/car_stream_if.sv
// ----------------------------------------------------------------------------
// car_stream_if
// valid/ready channel carrying a payload of parameterized width
// ----------------------------------------------------------------------------
interface car_stream_if #(parameter int unsigned W = 32);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/car_front.sv
// ----------------------------------------------------------------------------
// car_front
// accepts elements, widens halves, tracks chunk max and position
// ----------------------------------------------------------------------------
module car_front #(
	parameter int unsigned MaxElements = 65536,
	parameter int unsigned PosW = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] in_value,
	input logic [car_pkg::CountW-1:0] total_count,
	input logic [car_pkg::CountW-1:0] chunk_len,
	input logic [31:0] index_base,
	input car_pkg::vtype_t value_type,
	output logic res_valid,
	input logic res_ready,
	output car_pkg::result_t res
);
	import car_pkg::*;

	localparam int unsigned CW = PosW + 1;

	logic [PosW-1:0] elem_q;
	logic [PosW-1:0] chunk_q;
	logic [31:0] best_q;
	logic [PosW-1:0] bpos_q;
	logic [31:0] v;
	logic [CW-1:0] total;
	logic [CW-1:0] clen;
	logic [CW-1:0] elem_nx;
	logic [CW-1:0] chunk_nx;
	logic take;
	logic last_chunk;
	logic emit;
	logic [31:0] nbest;
	logic [PosW-1:0] nbpos;
	logic [CW+CountW-1:0] tc_w;
	logic [CW+CountW-1:0] cl_w;

	assign in_ready = !res_valid || res_ready;
	assign v = (value_type == VT_HALF) ? half_to_single(in_value[15:0]) : in_value;

	assign tc_w = (CW + CountW)'(total_count);
	assign cl_w = (CW + CountW)'(chunk_len);
	assign total = (tc_w == '0) ? CW'(1) :
		(tc_w > (CW + CountW)'(MaxElements)) ? CW'(MaxElements) : CW'(tc_w);
	assign clen = (cl_w == '0) ? CW'(1) :
		(cl_w > (CW + CountW)'(MaxElements)) ? CW'(MaxElements) : CW'(cl_w);

	assign take = (chunk_q == '0) || greater(v, best_q, value_type);
	assign nbest = take ? v : best_q;
	assign nbpos = take ? elem_q : bpos_q;
	assign elem_nx = CW'(elem_q) + CW'(1);
	assign chunk_nx = CW'(chunk_q) + CW'(1);
	assign last_chunk = elem_nx >= total;
	assign emit = (chunk_nx >= clen) || last_chunk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= '0;
			chunk_q <= '0;
			best_q <= '0;
			bpos_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready && emit) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
			if (in_valid && in_ready) begin
				best_q <= nbest;
				bpos_q <= nbpos;
				chunk_q <= emit ? '0 : chunk_nx[PosW-1:0];
				elem_q <= last_chunk ? '0 : elem_nx[PosW-1:0];
				if (emit) begin
					res.value <= nbest;
					res.index <= 32'(nbpos) + index_base;
					res.set_done <= last_chunk;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("held result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_chunk |=> elem_q == '0 && chunk_q == '0)
		else $error("counters did not restart");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !emit |=> chunk_q != '0)
		else $error("chunk counter lost");
endmodule

FILE: hdl/car_back.sv
// ----------------------------------------------------------------------------
// car_back
// two-entry result queue decoupling the reducer from the output receiver
// ----------------------------------------------------------------------------
module car_back (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	output logic res_ready,
	input car_pkg::result_t res,
	car_stream_if.source out_ch
);
	import car_pkg::*;

	result_t mem_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;

	assign res_ready = (cnt_q != 2'd2);
	assign push = res_valid && res_ready;
	assign pop = out_ch.valid && out_ch.ready;
	assign out_ch.valid = (cnt_q != 2'd0);
	assign out_ch.data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) == (wp_q == rp_q) || cnt_q == 2'd2)
		else $error("queue pointers disagree");
endmodule

FILE: hdl/chunked_argmax_reduce_unit.sv
// ----------------------------------------------------------------------------
// chunked_argmax_reduce_unit
// segmented argmax over a stream of activation elements
// ----------------------------------------------------------------------------
// in_ch carries one 32-bit element per item (float32, half in the low bits,
// signed or unsigned int, chosen by value_type). out_ch carries one item per
// chunk end: {max_value, max_index, set_done}, max_index = position + base.
// configuration: cfg_we, cfg_idx, cfg_data; write 0 total_count,
// 1 chunk_len, 2 index_base, 3 value_type; only while the block is idle.
// throughput: one element per cycle while the result path has room; the compare
// and update happen in the front stage. A result passes through the result
// register and then the two-entry queue before it is offered on out_ch.
// reset clears counters, running max and the queue; registers return to
// total_count 1, chunk_len 1, index_base 0, float32.
// when out_ch stalls the queue absorbs two results and the result register
// a third, then in_ch.ready drops until space frees.
// ----------------------------------------------------------------------------
module chunked_argmax_reduce_unit #(
	parameter int unsigned MAX_ELEMENTS = 65536
) (
	input logic clk,
	input logic arst_n,
	car_stream_if.sink in_ch,
	car_stream_if.source out_ch,
	input logic cfg_we,
	input logic [car_pkg::CfgIdxW-1:0] cfg_idx,
	input logic [car_pkg::CfgDataW-1:0] cfg_data
);
	import car_pkg::*;

	localparam int unsigned PosW = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;

	logic [CountW-1:0] total_q;
	logic [CountW-1:0] chunk_q;
	logic [31:0] base_q;
	vtype_t type_q;
	logic res_valid;
	logic res_ready;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= CountW'(1);
			chunk_q <= CountW'(1);
			base_q <= '0;
			type_q <= VT_FLOAT;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TOTAL: total_q <= cfg_data[CountW-1:0];
				REG_CHUNK: chunk_q <= cfg_data[CountW-1:0];
				REG_BASE: base_q <= cfg_data;
				REG_TYPE: type_q <= vtype_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	car_front #(.MaxElements(MAX_ELEMENTS), .PosW(PosW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_value(in_ch.data),
		.total_count(total_q), .chunk_len(chunk_q), .index_base(base_q),
		.value_type(type_q),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	car_back u_back (
		.clk(clk), .arst_n(arst_n),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.out_ch(out_ch)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		!res_ready |-> out_ch.valid)
		else $error("queue full yet output idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_idx == REG_BASE |=> base_q == $past(cfg_data))
		else $error("index base write lost");
endmodule
